FILE: rtl/debounced_track_segmenter_defines.svh
// Assertion macros for the checker file.
`ifndef DEBOUNCED_TRACK_SEGMENTER_DEFINES_SVH
`define DEBOUNCED_TRACK_SEGMENTER_DEFINES_SVH

// Property checked outside reset.
`define DTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define DTS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/dts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dts_pkg;

   // Segment index saturates at this count minus one
   localparam int MAX_SEGMENTS = 256;
   localparam logic [7:0] SEG_LAST = 8'(MAX_SEGMENTS - 1);

   // Configuration reset values
   localparam logic [11:0] STRAIGHT_LOW_RESET   = 12'd1960;
   localparam logic [11:0] STRAIGHT_HIGH_RESET  = 12'd1968;
   localparam logic [3:0]  CONFIRM_NEEDED_RESET = 4'd4;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRAIGHT_LOW   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRAIGHT_HIGH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIRM_NEEDED = 2'd2;
   localparam int CSR_DATA_W = 12;

   // Output queue geometry
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   // Room for the largest burst of one sample
   localparam logic [FIFO_CNT_W-1:0] FIFO_ROOM_MAX = FIFO_CNT_W'(FIFO_DEPTH - 2);

   typedef struct packed {
      logic [11:0] reading;
      logic [15:0] distance;
      logic [31:0] stamp_ms;
      logic        lap_end;
   } req_type;

   typedef struct packed {
      logic [7:0]  seg_number;
      logic        seg_kind;
      logic [15:0] seg_length;
      logic [31:0] seg_duration;
      logic [15:0] seg_start;
      logic        lap_done;
   } rsp_type;

   typedef struct packed {
      logic [11:0] straight_low;
      logic [11:0] straight_high;
      logic [3:0]  confirm_needed;
   } cfg_type;

   // Results of one sample, in order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } step_type;

endpackage
`default_nettype wire

FILE: rtl/debounced_track_segmenter.sv
`timescale 1ns / 1ps
`default_nettype none
// Splits a lap of track samples into straight and bend segments with a
// debounce run count. A sample is taken into an input register, classified
// and folded into the segment state as it leaves that register, and its zero,
// one or two results go into a four-entry output queue that drives rsp_data.
// A sample can be taken every cycle while the input does not stall. A sample
// that both closes a segment and ends the lap puts two results in the queue,
// which drains one per cycle while rsp_ready is high. The input stalls while
// a sample waits in the input register and the queue holds more than two
// results. Two such samples in a row cause this, and so does a stalled result
// side. rsp_valid rises once a sample's results are written into the queue.
// Configuration writes take effect on the next sample.
module debounced_track_segmenter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire dts_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output dts_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [dts_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [dts_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   dts_pkg::cfg_type  cfg_ff;
   logic              s1_valid_ff;
   dts_pkg::req_type  s1_item_ff;
   logic              room;
   logic              advance;
   dts_pkg::step_type step;

   assign csr_ready = 1'b1;
   assign advance   = s1_valid_ff && room;
   assign req_ready = !s1_valid_ff || advance;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.straight_low   <= dts_pkg::STRAIGHT_LOW_RESET;
         cfg_ff.straight_high  <= dts_pkg::STRAIGHT_HIGH_RESET;
         cfg_ff.confirm_needed <= dts_pkg::CONFIRM_NEEDED_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dts_pkg::CSR_STRAIGHT_LOW: begin
               cfg_ff.straight_low <= csr_wdata;
            end
            dts_pkg::CSR_STRAIGHT_HIGH: begin
               cfg_ff.straight_high <= csr_wdata;
            end
            dts_pkg::CSR_CONFIRM_NEEDED: begin
               cfg_ff.confirm_needed <= csr_wdata[3:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Hold the accepted transaction until the queue has room
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_data;
      end
   end

   dts_core u_core (
      .clock (clock),
      .reset (reset),
      .go    (advance),
      .item  (s1_item_ff),
      .cfg   (cfg_ff),
      .step  (step)
   );

   dts_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (step),
      .pop        (rsp_valid && rsp_ready),
      .head       (rsp_data),
      .head_valid (rsp_valid),
      .room       (room)
   );

endmodule
`default_nettype wire

FILE: rtl/dts_core.sv
`timescale 1ns / 1ps
`default_nettype none
module dts_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire dts_pkg::req_type item,
   input  wire dts_pkg::cfg_type cfg,
   output dts_pkg::step_type     step
);

   logic        open_flag_ff, open_flag_in;
   logic        open_kind_ff, open_kind_in;
   logic [3:0]  other_run_ff, other_run_in;
   logic [15:0] start_dist_ff, start_dist_in;
   logic [31:0] start_time_ff, start_time_in;
   logic [15:0] run_dist_ff, run_dist_in;
   logic [31:0] run_time_ff, run_time_in;
   logic [7:0]  seg_count_ff, seg_count_in;
   logic [15:0] last_dist_ff;
   logic [31:0] last_time_ff;

   logic             kind;
   logic [3:0]       run_inc;
   logic             close_seg;
   dts_pkg::rsp_type close_rsp;
   dts_pkg::rsp_type lap_rsp;

   // Classify the reading against the straight window
   assign kind = !((item.reading >= cfg.straight_low) &&
                   (item.reading <= cfg.straight_high));
   assign run_inc = other_run_ff + 4'd1;

   // Work out the next segment state and the results of this sample
   always_comb begin
      open_flag_in  = open_flag_ff;
      open_kind_in  = open_kind_ff;
      other_run_in  = other_run_ff;
      start_dist_in = start_dist_ff;
      start_time_in = start_time_ff;
      run_dist_in   = run_dist_ff;
      run_time_in   = run_time_ff;
      seg_count_in  = seg_count_ff;
      close_seg     = 1'b0;
      close_rsp     = '0;

      if (!open_flag_ff) begin
         open_flag_in  = 1'b1;
         open_kind_in  = kind;
         other_run_in  = 4'd0;
         start_dist_in = item.distance;
         start_time_in = item.stamp_ms;
      end else if (kind == open_kind_ff) begin
         other_run_in = 4'd0;
      end else begin
         // Remember the boundary sample at the start of a run
         if (other_run_ff == 4'd0) begin
            run_dist_in = last_dist_ff;
            run_time_in = last_time_ff;
         end
         other_run_in = run_inc;
         if (run_inc >= cfg.confirm_needed) begin
            close_seg = 1'b1;
            close_rsp.seg_number   = seg_count_ff;
            close_rsp.seg_kind     = open_kind_ff;
            close_rsp.seg_length   = run_dist_in - start_dist_ff;
            close_rsp.seg_duration = run_time_in - start_time_ff;
            close_rsp.seg_start    = start_dist_ff;
            close_rsp.lap_done     = 1'b0;
            if (seg_count_ff < dts_pkg::SEG_LAST) begin
               seg_count_in = seg_count_ff + 8'd1;
            end
            start_dist_in = run_dist_in;
            start_time_in = run_time_in;
            open_kind_in  = kind;
            other_run_in  = 4'd0;
         end
      end

      // Final segment of the lap ends at this sample
      lap_rsp.seg_number   = seg_count_in;
      lap_rsp.seg_kind     = open_kind_in;
      lap_rsp.seg_length   = item.distance - start_dist_in;
      lap_rsp.seg_duration = item.stamp_ms - start_time_in;
      lap_rsp.seg_start    = start_dist_in;
      lap_rsp.lap_done     = 1'b1;
      if (item.lap_end) begin
         open_flag_in = 1'b0;
         other_run_in = 4'd0;
         seg_count_in = 8'd0;
      end
   end

   // Order the results: close first, lap end second
   always_comb begin
      step.count  = {1'b0, close_seg} + {1'b0, item.lap_end};
      step.first  = close_seg ? close_rsp : lap_rsp;
      step.second = lap_rsp;
      if (!go) begin
         step.count = 2'd0;
      end
   end

   // Advance the state on each processed sample
   always_ff @(posedge clock) begin
      if (reset) begin
         open_flag_ff  <= 1'b0;
         open_kind_ff  <= 1'b0;
         other_run_ff  <= 4'd0;
         start_dist_ff <= 16'd0;
         start_time_ff <= 32'd0;
         run_dist_ff   <= 16'd0;
         run_time_ff   <= 32'd0;
         seg_count_ff  <= 8'd0;
         last_dist_ff  <= 16'd0;
         last_time_ff  <= 32'd0;
      end else if (go) begin
         open_flag_ff  <= open_flag_in;
         open_kind_ff  <= open_kind_in;
         other_run_ff  <= other_run_in;
         start_dist_ff <= start_dist_in;
         start_time_ff <= start_time_in;
         run_dist_ff   <= run_dist_in;
         run_time_ff   <= run_time_in;
         seg_count_ff  <= seg_count_in;
         last_dist_ff  <= item.distance;
         last_time_ff  <= item.stamp_ms;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/dts_rsp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module dts_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dts_pkg::step_type push,
   input  wire logic              pop,
   output dts_pkg::rsp_type       head,
   output logic                   head_valid,
   output logic                   room
);

   dts_pkg::rsp_type entry_ff [dts_pkg::FIFO_DEPTH];
   logic [dts_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dts_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dts_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic [dts_pkg::FIFO_PTR_W-1:0] wr_next;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign room       = (count_ff <= dts_pkg::FIFO_ROOM_MAX);
   assign wr_next    = wr_ptr_ff + dts_pkg::FIFO_PTR_W'(1);

   // Move pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + dts_pkg::FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + dts_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + dts_pkg::FIFO_CNT_W'(push.count)
                  - dts_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store up to two results per cycle
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/dts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "debounced_track_segmenter_defines.svh"
module dts_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire dts_pkg::rsp_type rsp_data
);

   // Hold a stalled result transaction
   `DTS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // Come out of reset with an empty queue
   `DTS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // Stall input only while results wait
   `DTS_ASSERT(a_stall_cause, clock, reset, !req_ready |-> rsp_valid, "input stalled with no result pending")

endmodule

bind debounced_track_segmenter dts_checker u_dts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: bench/debounced_track_segmenter_tb.sv
`timescale 1ns / 1ps
module debounced_track_segmenter_tb;

   // Index with no register behind it; writes to it change nothing
   localparam logic [dts_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      dts_pkg::req_type smp;
      bit               typed;
      dts_pkg::rsp_type want;
   } plan_row_type;

   typedef struct {
      logic [11:0] low;
      logic [11:0] high;
      logic [3:0]  confirm;
      int          items;
      bit          gaps;
      bit          alternate;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   dts_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b1;
   dts_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [dts_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [dts_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Expected segments, oldest first
   dts_pkg::rsp_type pending_segs[$];
   plan_row_type plan[$];
   phase_type phases[7];
   int fail_count = 0;
   bit rsp_stalls = 1'b0;
   int rsp_hold = 0;

   // Predictor copy of the configuration and the segment tracker
   logic [11:0] cfg_low = dts_pkg::STRAIGHT_LOW_RESET;
   logic [11:0] cfg_high = dts_pkg::STRAIGHT_HIGH_RESET;
   logic [3:0]  cfg_confirm = dts_pkg::CONFIRM_NEEDED_RESET;
   logic        trk_open = 1'b0;
   logic        trk_kind = 1'b0;
   logic [3:0]  trk_run = '0;
   logic [15:0] seg_dist = '0;
   logic [31:0] seg_time = '0;
   logic [15:0] bnd_dist = '0;
   logic [31:0] bnd_time = '0;
   logic [7:0]  seg_index = '0;
   logic [15:0] prev_dist = '0;
   logic [31:0] prev_time = '0;

   debounced_track_segmenter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #5_000_000;
      $display("FAIL debounced_track_segmenter");
      $finish;
   end

   // Build the segment that ends at the given point
   function automatic dts_pkg::rsp_type close_segment(logic [15:0] end_dist,
                                                      logic [31:0] end_time, logic done);
      dts_pkg::rsp_type seg;
      seg.seg_number = seg_index;
      seg.seg_kind = trk_kind;
      seg.seg_length = end_dist - seg_dist;
      seg.seg_duration = end_time - seg_time;
      seg.seg_start = seg_dist;
      seg.lap_done = done;
      return seg;
   endfunction

   // Fold one sample into the tracker and return the segments it closes
   task automatic fold_sample(input dts_pkg::req_type s, output int n,
                              output dts_pkg::rsp_type first,
                              output dts_pkg::rsp_type second);
      logic kind;
      dts_pkg::rsp_type seg;
      kind = !(s.reading >= cfg_low && s.reading <= cfg_high);
      n = 0;
      first = '0;
      second = '0;
      if (!trk_open) begin
         trk_open = 1'b1;
         trk_kind = kind;
         trk_run = '0;
         seg_dist = s.distance;
         seg_time = s.stamp_ms;
      end else if (kind == trk_kind) begin
         trk_run = '0;
      end else begin
         // remember the last sample before the run as the boundary
         if (trk_run == 0) begin
            bnd_dist = prev_dist;
            bnd_time = prev_time;
         end
         trk_run = trk_run + 4'd1;
         if (trk_run >= cfg_confirm) begin
            first = close_segment(bnd_dist, bnd_time, 1'b0);
            n = 1;
            if (seg_index != dts_pkg::SEG_LAST) seg_index = seg_index + 8'd1;
            seg_dist = bnd_dist;
            seg_time = bnd_time;
            trk_kind = kind;
            trk_run = '0;
         end
      end
      // lap end closes whatever is open and restarts numbering
      if (s.lap_end) begin
         seg = close_segment(s.distance, s.stamp_ms, 1'b1);
         if (n == 0) first = seg;
         else second = seg;
         n++;
         trk_open = 1'b0;
         trk_run = '0;
         seg_index = '0;
      end
      prev_dist = s.distance;
      prev_time = s.stamp_ms;
   endtask

   // Pick a reading of the wanted kind under the current window
   function automatic logic [11:0] pick_reading(bit bend);
      if (cfg_low > cfg_high) return 12'($urandom_range(4095, 0));
      if (!bend) return 12'($urandom_range(cfg_high, cfg_low));
      if (cfg_low > 0 && (cfg_high == 12'hFFF || $urandom_range(1, 0) == 1))
         return 12'($urandom_range(cfg_low - 1, 0));
      if (cfg_high < 12'hFFF) return 12'($urandom_range(4095, cfg_high + 1));
      return 12'($urandom_range(cfg_high, cfg_low));
   endfunction

   task automatic add_row(logic [11:0] r, logic [15:0] d, logic [31:0] t, logic e,
                          bit typed, dts_pkg::rsp_type want);
      plan_row_type row;
      row.smp.reading = r;
      row.smp.distance = d;
      row.smp.stamp_ms = t;
      row.smp.lap_end = e;
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endtask

   // Present one sample; hold valid high on return, the caller decides
   task automatic send_sample(input dts_pkg::req_type s, input bit typed,
                              input dts_pkg::rsp_type want);
      int n;
      dts_pkg::rsp_type first;
      dts_pkg::rsp_type second;
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (!req_ready);
      fold_sample(s, n, first, second);
      if (typed) begin
         pending_segs.push_back(want);
      end else begin
         if (n > 0) pending_segs.push_back(first);
         if (n > 1) pending_segs.push_back(second);
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [dts_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [11:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         dts_pkg::CSR_STRAIGHT_LOW: cfg_low = data;
         dts_pkg::CSR_STRAIGHT_HIGH: cfg_high = data;
         dts_pkg::CSR_CONFIRM_NEEDED: cfg_confirm = data[3:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_segs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Result side backpressure in random bursts
   always @(negedge clock) begin
      if (reset || !rsp_stalls) begin
         rsp_hold = 0;
         rsp_ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(5, 0) == 0) begin
         rsp_hold = $urandom_range(6, 0);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check every result transaction against the oldest expectation
   always @(posedge clock) begin
      dts_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_segs.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t unexpected segment %h", $realtime, rsp_data);
         end else begin
            want = pending_segs.pop_front();
            if (rsp_data.seg_number !== want.seg_number || rsp_data.seg_kind !== want.seg_kind ||
                rsp_data.seg_length !== want.seg_length ||
                rsp_data.seg_duration !== want.seg_duration ||
                rsp_data.seg_start !== want.seg_start || rsp_data.lap_done !== want.lap_done) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display({"%0t segment mismatch: exp num=%0d kind=%0d len=%h dur=%h ",
                            "start=%h done=%0d, got num=%0d kind=%0d len=%h dur=%h ",
                            "start=%h done=%0d"},
                           $realtime, want.seg_number, want.seg_kind, want.seg_length,
                           want.seg_duration, want.seg_start, want.lap_done,
                           rsp_data.seg_number, rsp_data.seg_kind, rsp_data.seg_length,
                           rsp_data.seg_duration, rsp_data.seg_start, rsp_data.lap_done);
            end
         end
      end
   end

   initial begin
      int lap_left;
      int burst_left;
      bit burst_bend;
      bit want_bend;
      dts_pkg::req_type s;
      logic [15:0] pos_dist;
      logic [31:0] pos_stamp;

      // Directed samples under the reset window 1960..1968, confirm 4
      add_row(12'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
              '{8'd0, 1'b1, 16'd0, 32'd0, 16'hFFFF, 1'b1});
      add_row(12'd4095, 16'd0, 32'd0, 1'b1, 1'b1,
              '{8'd0, 1'b1, 16'd0, 32'd0, 16'd0, 1'b1});
      add_row(12'd1960, 16'd1234, 32'd5, 1'b1, 1'b1,
              '{8'd0, 1'b0, 16'd0, 32'd0, 16'd1234, 1'b1});
      add_row(12'd1968, 16'd0, 32'd0, 1'b1, 1'b1,
              '{8'd0, 1'b0, 16'd0, 32'd0, 16'd0, 1'b1});
      // bend lap wrapping distance and time, a cleared run, then a close
      add_row(12'd1959, 16'd65500, 32'hFFFF_FF00, 1'b0, 1'b0, '0);
      add_row(12'd1969, 16'd65520, 32'hFFFF_FF80, 1'b0, 1'b0, '0);
      add_row(12'd1964, 16'd65530, 32'hFFFF_FFF0, 1'b0, 1'b0, '0);
      add_row(12'd2000, 16'd10, 32'h10, 1'b0, 1'b0, '0);
      add_row(12'd1961, 16'd20, 32'h20, 1'b0, 1'b0, '0);
      add_row(12'd1962, 16'd30, 32'h30, 1'b0, 1'b0, '0);
      add_row(12'd1963, 16'd40, 32'h40, 1'b0, 1'b0, '0);
      add_row(12'd1960, 16'd50, 32'h50, 1'b0, 1'b0, '0);
      add_row(12'd1967, 16'd60, 32'h60, 1'b0, 1'b0, '0);
      add_row(12'd100, 16'd70, 32'h70, 1'b0, 1'b0, '0);
      add_row(12'd4000, 16'd80, 32'h80, 1'b0, 1'b0, '0);
      add_row(12'd0, 16'd90, 32'h90, 1'b0, 1'b0, '0);
      // close and lap end on the same sample
      add_row(12'd4095, 16'd100, 32'hA0, 1'b1, 1'b0, '0);
      add_row(12'd1964, 16'd200, 32'h1000, 1'b0, 1'b0, '0);
      add_row(12'd1964, 16'd300, 32'h2000, 1'b1, 1'b0, '0);

      // full window, empty window with confirm zero, wide, reset, random,
      // single-value window for a long lap, then a quiet tail
      phases[0] = '{12'd0, 12'd4095, 4'd15, 80, 1'b1, 1'b0};
      phases[1] = '{12'd4095, 12'd0, 4'd0, 80, 1'b1, 1'b0};
      phases[2] = '{12'd1000, 12'd3000, 4'd1, 120, 1'b1, 1'b0};
      phases[3] = '{12'd1960, 12'd1968, 4'd4, 120, 1'b0, 1'b0};
      phases[4] = '{12'($urandom_range(2047, 0)), 12'($urandom_range(4095, 2048)),
                    4'($urandom_range(15, 2)), 120, 1'b1, 1'b0};
      phases[5] = '{12'd2048, 12'd2048, 4'd1, 300, 1'b1, 1'b1};
      phases[6] = '{12'd0, 12'd2047, 4'd3, 80, 1'b0, 1'b0};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      rsp_stalls = 1'b1;

      foreach (plan[k]) send_sample(plan[k].smp, plan[k].typed, plan[k].want);

      pos_dist = 16'($urandom);
      pos_stamp = $urandom;
      burst_left = 0;
      burst_bend = 1'b0;
      foreach (phases[p]) begin
         // reconfigure only with nothing in flight
         drain_results();
         write_csr(dts_pkg::CSR_STRAIGHT_LOW, phases[p].low);
         write_csr(dts_pkg::CSR_STRAIGHT_HIGH, phases[p].high);
         write_csr(dts_pkg::CSR_CONFIRM_NEEDED, {8'($urandom), phases[p].confirm});
         if (p == 2) write_csr(CSR_UNUSED, 12'($urandom));
         csr_valid <= 1'b0;
         rsp_stalls = phases[p].gaps;
         lap_left = phases[p].alternate ? phases[p].items : 0;

         for (int i = 0; i < phases[p].items; i++) begin
            if (burst_left == 0) begin
               burst_bend = $urandom_range(1, 0);
               burst_left = $urandom_range(cfg_confirm + 2, 1);
            end
            burst_left--;
            want_bend = phases[p].alternate ? i[0] : burst_bend;
            if (!phases[p].alternate && $urandom_range(9, 0) == 0)
               s.reading = 12'($urandom);
            else
               s.reading = pick_reading(want_bend);
            if ($urandom_range(19, 0) == 0) pos_dist = 16'($urandom);
            else pos_dist = pos_dist + 16'($urandom_range(400, 0));
            if ($urandom_range(29, 0) == 0) pos_stamp = $urandom;
            else pos_stamp = pos_stamp + $urandom_range(2000, 0);
            s.distance = pos_dist;
            s.stamp_ms = pos_stamp;
            if (lap_left == 0) lap_left = $urandom_range(40, 1);
            s.lap_end = (lap_left == 1);
            lap_left--;

            // sender idles in bursts, and now and then waits for all results
            if (phases[p].gaps && $urandom_range(3, 0) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(7, 1)) @(negedge clock);
            end else if (phases[p].gaps && $urandom_range(59, 0) == 0) begin
               req_valid <= 1'b0;
               @(negedge clock);
               while (pending_segs.size() != 0) @(negedge clock);
            end
            send_sample(s, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_segs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_segs.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("PASS debounced_track_segmenter");
      end else begin
         $display("FAIL debounced_track_segmenter");
      end
      $finish;
   end

endmodule
